// File: src/gbp_pkg.sv
// Shared constants, codes and types for the gshare predictor with BTB.
// Used by gbp_ctrl, gbp_datapath and the top level.
`timescale 1ns / 1ps

package gbp_pkg;

   localparam int BTB_ENTRIES  = 1024;
   localparam int PHT_ENTRIES  = 256;
   localparam int HISTORY_BITS = 8;
   localparam int BTB_IDX_W    = $clog2(BTB_ENTRIES);
   localparam int PHT_IDX_W    = $clog2(PHT_ENTRIES);
   localparam int PC_W         = 64;
   localparam int CTR_W        = 2;

   localparam logic [CTR_W-1:0] CTR_MIN   = 2'd0;
   localparam logic [CTR_W-1:0] CTR_MAX   = 2'd3;
   localparam logic [CTR_W-1:0] CTR_TAKEN = 2'd2;
   localparam logic [PC_W-1:0]  PC_STEP   = 64'd4;

   localparam logic MODE_PREDICT = 1'b0;
   localparam logic MODE_UPDATE  = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic                 load;
      logic                 commit;
      logic                 clear;
      logic [BTB_IDX_W-1:0] clear_idx;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_update;
      logic out_ready;
   } sts_type;

   typedef struct packed {
      logic            valid;
      logic            cond;
      logic [PC_W-1:0] tag;
      logic [PC_W-1:0] dest;
   } btb_entry_type;

endpackage

// File: src/gbp_ctrl.sv
// Sequencer for the predictor: reset clear pass, word accept, lookup/commit.
// Depends on gbp_pkg.
`timescale 1ns / 1ps

module gbp_ctrl
   import gbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type            state_ff, state_in;
   logic [BTB_IDX_W-1:0] clear_cnt_ff, clear_cnt_in;
   logic                 clear_last;

   assign clear_last = (clear_cnt_ff == BTB_IDX_W'(BTB_ENTRIES - 1));
   assign req_stall  = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      cmd.load      = 1'b0;
      cmd.commit    = 1'b0;
      cmd.clear     = 1'b0;
      cmd.clear_idx = clear_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear    = 1'b1;
            clear_cnt_in = clear_cnt_ff + BTB_IDX_W'(1);
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // a prediction waits here until the output register frees up
            if (sts.is_update || sts.out_ready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   a_reset_starts_clear: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_CLEAR && clear_cnt_ff == '0))
      else $error("clear pass not started after reset");

   a_pred_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && !sts.is_update && !sts.out_ready)
      |=> (state_ff == ST_LOOKUP))
      else $error("prediction left lookup while output register busy");

endmodule

// File: src/gbp_datapath.sv
// BTB and pattern history memories, global history, request and result registers.
// Depends on gbp_pkg; driven by gbp_ctrl commands.
`timescale 1ns / 1ps

module gbp_datapath
   import gbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output sts_type         sts,
   input  logic            req_mode,
   input  logic [PC_W-1:0] req_pc,
   input  logic            req_taken,
   input  logic            req_is_conditional,
   input  logic [PC_W-1:0] req_branch_target,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [PC_W-1:0] rsp_next_pc,
   output logic            rsp_btb_miss,
   output logic            rsp_predict_taken
);

   btb_entry_type         btb_mem_ff [BTB_ENTRIES];
   logic [CTR_W-1:0]      pht_mem_ff [PHT_ENTRIES];

   btb_entry_type         btb_rd_ff;
   logic [CTR_W-1:0]      ctr_rd_ff;

   logic                  mode_ff, taken_ff, cond_ff;
   logic [PC_W-1:0]       pc_ff, target_ff;
   logic [PHT_IDX_W-1:0]  pht_idx_ff, pht_idx_in;
   logic [HISTORY_BITS-1:0] history_ff;

   logic                  rsp_valid_ff;
   logic [PC_W-1:0]       next_pc_ff, next_pc_in;
   logic                  miss_ff, taken_pred_ff;

   logic [BTB_IDX_W-1:0]  btb_idx_req, btb_idx_cur, btb_waddr;
   logic [PHT_IDX_W-1:0]  pht_waddr;
   btb_entry_type         btb_wdata;
   logic [CTR_W-1:0]      pht_wdata, ctr_next;
   logic                  btb_we, pht_we, upd_commit, cond_commit, pred_commit;
   logic                  hit, take;

   assign btb_idx_req = req_pc[BTB_IDX_W+1:2];
   assign btb_idx_cur = pc_ff[BTB_IDX_W+1:2];
   assign pht_idx_in  = req_pc[PHT_IDX_W+1:2] ^ PHT_IDX_W'(history_ff);

   assign upd_commit  = cmd.commit && (mode_ff == MODE_UPDATE);
   assign cond_commit = upd_commit && cond_ff;
   assign pred_commit = cmd.commit && (mode_ff == MODE_PREDICT);

   // lookup
   assign hit        = btb_rd_ff.valid && (btb_rd_ff.tag == pc_ff);
   assign take       = hit && (!btb_rd_ff.cond || (ctr_rd_ff >= CTR_TAKEN));
   assign next_pc_in = take ? btb_rd_ff.dest : (pc_ff + PC_STEP);

   // saturating counter
   always_comb begin
      if (taken_ff) begin
         ctr_next = (ctr_rd_ff == CTR_MAX) ? ctr_rd_ff : ctr_rd_ff + CTR_W'(1);
      end else begin
         ctr_next = (ctr_rd_ff == CTR_MIN) ? ctr_rd_ff : ctr_rd_ff - CTR_W'(1);
      end
   end

   // write ports: clear pass or update commit
   always_comb begin
      btb_we          = cmd.clear || upd_commit;
      btb_waddr       = cmd.clear ? cmd.clear_idx : btb_idx_cur;
      btb_wdata.valid = !cmd.clear;
      btb_wdata.cond  = cond_ff;
      btb_wdata.tag   = pc_ff;
      btb_wdata.dest  = target_ff;
      pht_we          = cmd.clear || cond_commit;
      pht_waddr       = cmd.clear ? cmd.clear_idx[PHT_IDX_W-1:0] : pht_idx_ff;
      pht_wdata       = cmd.clear ? CTR_MIN : ctr_next;
   end

   always_ff @(posedge clock) begin
      if (btb_we) begin
         btb_mem_ff[btb_waddr] <= btb_wdata;
      end
      if (cmd.load) begin
         btb_rd_ff <= btb_mem_ff[btb_idx_req];
      end
   end

   always_ff @(posedge clock) begin
      if (pht_we) begin
         pht_mem_ff[pht_waddr] <= pht_wdata;
      end
      if (cmd.load) begin
         ctr_rd_ff <= pht_mem_ff[pht_idx_in];
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         pc_ff      <= req_pc;
         taken_ff   <= req_taken;
         cond_ff    <= req_is_conditional;
         target_ff  <= req_branch_target;
         pht_idx_ff <= pht_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else if (cond_commit) begin
         history_ff <= {history_ff[HISTORY_BITS-2:0], taken_ff};
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pred_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pred_commit) begin
         next_pc_ff    <= next_pc_in;
         miss_ff       <= !hit;
         taken_pred_ff <= take;
      end
   end

   assign sts.is_update     = (mode_ff == MODE_UPDATE);
   assign sts.out_ready     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = next_pc_ff;
   assign rsp_btb_miss      = miss_ff;
   assign rsp_predict_taken = taken_pred_ff;

   a_pred_gives_word: assert property (@(posedge clock) disable iff (reset)
      pred_commit |=> (rsp_valid_ff && $stable(history_ff)))
      else $error("prediction commit did not load result word");

   a_history_only_on_cond: assert property (@(posedge clock) disable iff (reset)
      (!cond_commit && !$past(reset)) |=> $stable(history_ff))
      else $error("history changed without conditional update");

endmodule

// File: src/gshare_branch_predictor_btb.sv
// Top level of the gshare branch predictor with branch target buffer.
// Depends on gbp_pkg, gbp_ctrl and gbp_datapath.
`timescale 1ns / 1ps
//
// Usage:
//  - req_* channel carries one word per predict (req_mode = 0) or update
//    (req_mode = 1). A word is taken when req_valid is high and req_stall low.
//  - rsp_* channel returns one word per predict: next fetch pc, BTB miss and
//    predicted-taken flags. Updates return nothing.
//  - A predict reads the tables into registers when accepted, and loads the
//    result register from lookup once that register is free.
//  - A new word is accepted only after the current one leaves lookup. Each
//    word reads the BTB and pattern table memories when accepted and writes
//    them (update) or loads the result register (predict) in lookup.
//  - Reset: synchronous, active high. Afterwards a clear pass invalidates
//    every BTB entry and zeroes the pattern counters; req_stall stays high
//    during it. Global history resets to zero.
//  - rsp_stall: the result word holds in its register. The next word can
//    still be taken; a following predict waits in lookup until the register
//    drains, an update completes regardless.
//
module gshare_branch_predictor_btb
   import gbp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_mode,
   input  logic [PC_W-1:0] req_pc,
   input  logic            req_taken,
   input  logic            req_is_conditional,
   input  logic [PC_W-1:0] req_branch_target,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [PC_W-1:0] rsp_next_pc,
   output logic            rsp_btb_miss,
   output logic            rsp_predict_taken
);

   cmd_type cmd;
   sts_type sts;

   gbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_mode           (req_mode),
      .req_pc             (req_pc),
      .req_taken          (req_taken),
      .req_is_conditional (req_is_conditional),
      .req_branch_target  (req_branch_target),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_btb_miss       (rsp_btb_miss),
      .rsp_predict_taken  (rsp_predict_taken)
   );

endmodule

// File: bench/gshare_branch_predictor_btb_test.sv
// Self-checking testbench for gshare_branch_predictor_btb: directed and random
// predict/update traffic checked against a shadow copy of the BTB and pattern table.
// Depends on gbp_pkg and the gshare_branch_predictor_btb RTL.
`timescale 1ns / 1ps

module gshare_branch_predictor_btb_test;
   import gbp_pkg::*;

   typedef struct packed {
      logic [PC_W-1:0] next_pc;
      logic            lookup_miss;
      logic            predict_taken;
   } fetch_guess_type;

   localparam int POOL_SIZE = 32;

   logic            clock              = 1'b0;
   logic            reset              = 1'b1;
   logic            req_valid          = 1'b0;
   logic            req_stall;
   logic            req_mode           = MODE_PREDICT;
   logic [PC_W-1:0] req_pc             = '0;
   logic            req_taken          = 1'b0;
   logic            req_is_conditional = 1'b0;
   logic [PC_W-1:0] req_branch_target  = '0;
   logic            rsp_valid;
   logic            rsp_stall          = 1'b0;
   logic [PC_W-1:0] rsp_next_pc;
   logic            rsp_btb_miss;
   logic            rsp_predict_taken;

   gshare_branch_predictor_btb u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_pc             (req_pc),
      .req_taken          (req_taken),
      .req_is_conditional (req_is_conditional),
      .req_branch_target  (req_branch_target),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_next_pc        (rsp_next_pc),
      .rsp_btb_miss       (rsp_btb_miss),
      .rsp_predict_taken  (rsp_predict_taken)
   );

   // shadow copy of the predictor tables
   logic                    shadow_valid [BTB_ENTRIES];
   logic                    shadow_cond  [BTB_ENTRIES];
   logic [PC_W-1:0]         shadow_tag   [BTB_ENTRIES];
   logic [PC_W-1:0]         shadow_dest  [BTB_ENTRIES];
   logic [CTR_W-1:0]        shadow_ctr   [PHT_ENTRIES];
   logic [HISTORY_BITS-1:0] shadow_history;

   fetch_guess_type expected_guesses [$];
   int              error_count   = 0;
   int              send_idle_pct = 0;
   int              stall_pct     = 0;

   logic [PC_W-1:0] pool_pc   [POOL_SIZE];
   logic            pool_bias [POOL_SIZE];

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("gshare_branch_predictor_btb_test NOT OK");
      $finish;
   end

   function automatic logic [PC_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic int btb_row(input logic [PC_W-1:0] pc);
      return int'((pc >> 2) % 64'(BTB_ENTRIES));
   endfunction

   function automatic int pht_row(input logic [PC_W-1:0] pc);
      return int'(((pc >> 2) ^ PC_W'(shadow_history)) % 64'(PHT_ENTRIES));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Applies one accepted word to the shadow tables; predicts queue a guess.
   function automatic void shadow_branch_word(input logic mode, input logic [PC_W-1:0] pc,
                                              input logic taken, input logic cond,
                                              input logic [PC_W-1:0] target);
      int              bi;
      int              pi;
      fetch_guess_type guess;
      bi = btb_row(pc);
      if (mode == MODE_PREDICT) begin
         guess.next_pc       = pc + PC_STEP;
         guess.lookup_miss   = 1'b1;
         guess.predict_taken = 1'b0;
         if (shadow_valid[bi] && shadow_tag[bi] == pc) begin
            guess.lookup_miss = 1'b0;
            if (!shadow_cond[bi] || shadow_ctr[pht_row(pc)] >= CTR_TAKEN) begin
               guess.predict_taken = 1'b1;
               guess.next_pc       = shadow_dest[bi];
            end
         end
         expected_guesses.push_back(guess);
      end else begin
         if (cond) begin
            pi = pht_row(pc);
            if (taken && shadow_ctr[pi] != CTR_MAX)
               shadow_ctr[pi] = shadow_ctr[pi] + 2'd1;
            else if (!taken && shadow_ctr[pi] != CTR_MIN)
               shadow_ctr[pi] = shadow_ctr[pi] - 2'd1;
            shadow_history = {shadow_history[HISTORY_BITS-2:0], taken};
         end
         shadow_valid[bi] = 1'b1;
         shadow_tag[bi]   = pc;
         shadow_cond[bi]  = cond;
         shadow_dest[bi]  = target;
      end
   endfunction

   // Leaves req_valid high on return so a following word goes out back to back.
   task automatic send_word(input logic mode, input logic [PC_W-1:0] pc, input logic taken,
                            input logic cond, input logic [PC_W-1:0] target);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_mode           <= mode;
      req_pc             <= pc;
      req_taken          <= taken;
      req_is_conditional <= cond;
      req_branch_target  <= target;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow_branch_word(mode, pc, taken, cond, target);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_guesses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin
      fetch_guess_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_guesses.size() == 0) begin
            report_mismatch($sformatf("unexpected result next_pc=%h", rsp_next_pc));
         end else begin
            want = expected_guesses.pop_front();
            if (rsp_next_pc !== want.next_pc)
               report_mismatch($sformatf("next_pc %h, want %h", rsp_next_pc, want.next_pc));
            if (rsp_btb_miss !== want.lookup_miss)
               report_mismatch($sformatf("miss flag %b, want %b", rsp_btb_miss,
                                         want.lookup_miss));
            if (rsp_predict_taken !== want.predict_taken)
               report_mismatch($sformatf("predict_taken %b, want %b",
                                         rsp_predict_taken, want.predict_taken));
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Empty table: every lookup misses, including pc + 4 wrapping past the top.
   task automatic test_empty_table();
      send_word(MODE_PREDICT, 64'h0, 1'b1, 1'b1, '1);
      send_word(MODE_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 1'b0, '0);
      send_word(MODE_PREDICT, '1, 1'b1, 1'b0, '1);
   endtask

   task automatic test_unconditional_hit();
      send_word(MODE_UPDATE, 64'h0000_1234_5678_9ABC, 1'b1, 1'b0, '1);
      send_word(MODE_PREDICT, 64'h0000_1234_5678_9ABC, 1'b0, 1'b0, '0);
      send_word(MODE_UPDATE, '1, 1'b0, 1'b0, '0);
      send_word(MODE_PREDICT, '1, 1'b0, 1'b0, '0);
   endtask

   // Same BTB slot, different tag: miss, then the alias evicts the original.
   task automatic test_tag_alias();
      send_word(MODE_PREDICT, 64'h8000_1234_5678_9ABC, 1'b0, 1'b0, '0);
      send_word(MODE_UPDATE, 64'h8000_1234_5678_9ABC, 1'b0, 1'b0, 64'h0000_0000_00C0_FFEE);
      send_word(MODE_PREDICT, 64'h0000_1234_5678_9ABC, 1'b0, 1'b0, '0);
   endtask

   // Not-taken at zero holds the counter; a taken run fills the history, then
   // saturates the counter it lands on; not-taken steps back down.
   task automatic test_counter_saturation();
      logic [PC_W-1:0] pc;
      pc = 64'h0000_0000_0000_0040;
      send_word(MODE_UPDATE, pc, 1'b0, 1'b1, 64'h0000_0000_0000_1000);
      send_word(MODE_PREDICT, pc, 1'b0, 1'b0, '0);
      repeat (HISTORY_BITS + 4) send_word(MODE_UPDATE, pc, 1'b1, 1'b1, 64'h0000_0000_0000_1000);
      send_word(MODE_PREDICT, pc, 1'b0, 1'b0, '0);
      repeat (2) send_word(MODE_UPDATE, pc, 1'b0, 1'b1, 64'h0000_0000_0000_1000);
      send_word(MODE_PREDICT, pc, 1'b0, 1'b0, '0);
   endtask

   task automatic test_random_traffic(input int count);
      int              sent;
      int              kind;
      int              k;
      int              len;
      logic            t;
      logic [PC_W-1:0] pc;
      for (k = 0; k < POOL_SIZE; k++) begin
         pool_pc[k]   = random_word();
         pool_bias[k] = 1'($urandom_range(1));
      end
      // one hot branch near the top of the address space to hit the wrap
      pool_pc[0] = {PC_W{1'b1}} - PC_W'($urandom_range(7));
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         k    = $urandom_range(POOL_SIZE - 1);
         if (kind < 40) begin
            send_word(MODE_PREDICT, pool_pc[k], 1'($urandom_range(1)), 1'($urandom_range(1)),
                      random_word());
            sent++;
         end else if (kind < 70) begin
            t = pool_bias[k] ? ($urandom_range(9) != 0) : ($urandom_range(9) == 0);
            send_word(MODE_UPDATE, pool_pc[k], t, $urandom_range(4) != 0, random_word());
            sent++;
         end else if (kind < 80) begin
            // loop-like run with one outcome drives counters and history toward the rails
            t   = 1'($urandom_range(1));
            len = $urandom_range(4, 10);
            pc  = random_word();
            repeat (len) send_word(MODE_UPDATE, pool_pc[k], t, 1'b1, pc);
            send_word(MODE_PREDICT, pool_pc[k], 1'($urandom_range(1)), 1'($urandom_range(1)),
                      random_word());
            sent += len + 1;
         end else if (kind < 88) begin
            pc = pool_pc[k] ^ (random_word() << 12);
            send_word($urandom_range(3) == 0 ? MODE_UPDATE : MODE_PREDICT, pc,
                      1'($urandom_range(1)), 1'($urandom_range(1)), random_word());
            sent++;
         end else if (kind < 94) begin
            send_word(MODE_PREDICT, random_word(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), random_word());
            sent++;
         end else begin
            send_word(MODE_UPDATE, random_word(), 1'($urandom_range(1)),
                      1'($urandom_range(1)), random_word());
            sent++;
         end
      end
   endtask

   initial begin
      for (int i = 0; i < BTB_ENTRIES; i++) shadow_valid[i] = 1'b0;
      for (int i = 0; i < PHT_ENTRIES; i++) shadow_ctr[i] = CTR_MIN;
      shadow_history = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      stall_pct     = 57;
      test_empty_table();
      test_unconditional_hit();
      test_tag_alias();
      test_counter_saturation();
      test_random_traffic(600);
      wait_drained();

      send_idle_pct = 57;
      stall_pct     = 17;
      test_random_traffic(620);
      wait_drained();

      send_idle_pct = 0;
      stall_pct     = 0;
      test_random_traffic(630);
      wait_drained();
      repeat (16) @(posedge clock);

      if (error_count == 0)
         $display("gshare_branch_predictor_btb_test OK");
      else
         $display("gshare_branch_predictor_btb_test NOT OK");
      $finish;
   end

endmodule
